>>> design/slcfr_pkg.sv
// slcfr_pkg: shared types, constants and the crc-8 byte update for the
// sync/length/crc-8 frame receiver. No dependencies.
`timescale 1ns / 1ps

package slcfr_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_FIRST   = 8'hAD;
  localparam logic [7:0] SYNC_SECOND  = 8'hDA;
  // reflected dallas/maxim polynomial
  localparam logic [7:0] CRC_POLY_REF = 8'h8C;
  // command decode
  localparam logic [7:0] CMD_QUERY    = 8'h20;
  localparam logic [7:0] CMD_RELAY    = 8'h60;
  localparam logic [7:0] RELAY_CHAN   = 8'h01;
  localparam logic [7:0] BCAST_ADDR   = 8'hFF;
  localparam logic [7:0] BCAST_CMD    = 8'hF0;
  localparam logic [7:0] MIN_PAYLOAD  = 8'd2;

  // frame kind codes
  localparam logic [2:0] KIND_CRC_ERROR = 3'd0;
  localparam logic [2:0] KIND_QUERY     = 3'd1;
  localparam logic [2:0] KIND_RELAY     = 3'd2;
  localparam logic [2:0] KIND_PROBE     = 3'd3;
  localparam logic [2:0] KIND_OTHER     = 3'd4;
  localparam logic [2:0] KIND_NOT_ADDR  = 3'd5;

  // register indexes
  localparam logic REG_OWN_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0] relay_request;
    logic [7:0] channel_number;
    logic [7:0] command_code;
    logic       crc_good;
    logic [2:0] frame_kind;
  } result_t;

  // one byte of reflected crc-8, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY_REF;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/sync_length_crc8_frame_receiver.sv
// Output: a result is registered on m_axis in the cycle after its check byte is accepted.
// Throughput: one byte per cycle; the byte crc update and the classification sit
// between the state registers and the single output register, so input stalls
// only while that register holds a result that is not taken.
// Reset: synchronous rst returns to hunting the first sync byte, clears the
// frame state, own_address and the output valid.
`timescale 1ns / 1ps

// sync_length_crc8_frame_receiver: stream top level with apb config and output
// register. Depends on slcfr_pkg and slcfr_parser.
module sync_length_crc8_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] frame_kind, [3] crc_good,
                                      // [11:4] command_code, [19:12] channel_number,
                                      // [27:20] relay_request, [31:28] zero
);
  import slcfr_pkg::*;

  logic       in_valid;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic [7:0] own_address;
  logic       cfg_write;

  // config register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'd0;
    end else if (cfg_write && paddr[2] == REG_OWN_ADDRESS) begin
      own_address <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_OWN_ADDRESS) ? {24'd0, own_address} : 32'd0;

  // input handshake: accept whenever the output register frees up
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_valid      = s_axis_tvalid && s_axis_tready;

  slcfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_byte     (s_axis_tdata),
    .own_address (own_address),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'd0, out_res};

  // only defined kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_NOT_ADDR)
    else $error("undefined frame kind");

  // crc flag and kind agree
  a_good_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[2:0] != KIND_CRC_ERROR)))
    else $error("crc flag and kind disagree");

  // a parser result is never dropped while the output is blocked
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> s_axis_tready)
    else $error("result raised while output stalled");

  // config write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write && paddr[2] == REG_OWN_ADDRESS |=> own_address == $past(pwdata[7:0]))
    else $error("own address write lost");

endmodule

>>> design/slcfr_parser.sv
// slcfr_parser: sync hunt, length and payload tracking, running crc and frame
// classification for one received byte per cycle. Depends on slcfr_pkg.
`timescale 1ns / 1ps

module slcfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          own_address,
  output logic                res_valid,
  output slcfr_pkg::result_t  res
);
  import slcfr_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_channel, held_channel_next;
  logic [7:0] held_relay_state, held_relay_state_next;
  logic       in_payload;
  logic       good;

  assign in_payload = payload_count < payload_length;
  assign good       = in_byte == running_crc;

  // next state of the frame tracker
  always_comb begin
    phase_next            = phase;
    payload_length_next   = payload_length;
    payload_count_next    = payload_count;
    running_crc_next      = running_crc;
    held_address_next     = held_address;
    held_command_next     = held_command;
    held_channel_next     = held_channel;
    held_relay_state_next = held_relay_state;
    case (phase)
      PH_HUNT1: begin
        if (in_byte == SYNC_FIRST) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_next = (in_byte == SYNC_SECOND) ? PH_LENGTH : PH_HUNT1;
      end
      PH_LENGTH: begin
        payload_length_next   = in_byte;
        payload_count_next    = 8'd0;
        running_crc_next      = 8'd0;
        held_address_next     = 8'd0;
        held_command_next     = 8'd0;
        held_channel_next     = 8'd0;
        held_relay_state_next = 8'd0;
        phase_next            = PH_BODY;
      end
      PH_BODY: begin
        if (in_payload) begin
          // first four payload bytes are captured, all go into the crc
          case (payload_count)
            8'd0:    held_address_next     = in_byte;
            8'd1:    held_command_next     = in_byte;
            8'd2:    held_channel_next     = in_byte;
            8'd3:    held_relay_state_next = in_byte;
            default: ;
          endcase
          running_crc_next   = crc8_update(running_crc, in_byte);
          payload_count_next = payload_count + 8'd1;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
      default: phase_next = PH_HUNT1;
    endcase
  end

  // result on the check byte
  always_comb begin
    res_valid          = in_valid && (phase == PH_BODY) && !in_payload;
    res.crc_good       = good;
    res.command_code   = held_command;
    res.channel_number = held_channel;
    res.relay_request  = held_relay_state;
    if (!good) begin
      res.frame_kind = KIND_CRC_ERROR;
    end else if (payload_length < MIN_PAYLOAD) begin
      res.frame_kind = KIND_NOT_ADDR;
    end else if (held_address == own_address) begin
      if (held_command == CMD_QUERY) begin
        res.frame_kind = KIND_QUERY;
      end else if (held_command == CMD_RELAY && held_channel == RELAY_CHAN) begin
        res.frame_kind = KIND_RELAY;
      end else begin
        res.frame_kind = KIND_OTHER;
      end
    end else if (held_address == BCAST_ADDR && held_command == BCAST_CMD) begin
      res.frame_kind = KIND_PROBE;
    end else begin
      res.frame_kind = KIND_NOT_ADDR;
    end
  end

  // state registers, advanced on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT1;
      payload_length   <= 8'd0;
      payload_count    <= 8'd0;
      running_crc      <= 8'd0;
      held_address     <= 8'd0;
      held_command     <= 8'd0;
      held_channel     <= 8'd0;
      held_relay_state <= 8'd0;
    end else if (in_valid) begin
      phase            <= phase_next;
      payload_length   <= payload_length_next;
      payload_count    <= payload_count_next;
      running_crc      <= running_crc_next;
      held_address     <= held_address_next;
      held_command     <= held_command_next;
      held_channel     <= held_channel_next;
      held_relay_state <= held_relay_state_next;
    end
  end

  // count never runs past the length inside a frame
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> payload_count <= payload_length)
    else $error("payload count past length");

  // the length byte restarts the frame bookkeeping
  a_length_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && phase == PH_LENGTH |=>
      payload_count == 8'd0 && running_crc == 8'd0 && phase == PH_BODY)
    else $error("length byte did not restart frame");

  // a result only ends a frame
  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_HUNT1)
    else $error("result without return to hunt");

endmodule
